@@ design/websocket_frame_deframer_defines.svh @@
// assertion macros for the websocket frame deframer parser rtl
// no dependencies; clocked on clock and disabled while reset is high
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

// same-cycle implication
`define WSFD_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define WSFD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/wsfd_pkg.sv @@
// types, codes and helpers for the websocket frame deframer
// no dependencies
package wsfd_pkg;

   typedef enum logic [2:0] {
      PH_BYTE0   = 3'd0,
      PH_BYTE1   = 3'd1,
      PH_EXTLEN  = 3'd2,
      PH_KEY     = 3'd3,
      PH_PAYLOAD = 3'd4
   } phase_type;

   localparam logic KIND_HEADER  = 1'b0;
   localparam logic KIND_PAYLOAD = 1'b1;

   localparam logic [6:0] LEN7_MAX_DIRECT = 7'd125;
   localparam logic [6:0] LEN7_EXT16      = 7'd126;
   localparam logic [3:0] EXT16_START     = 4'd6;
   localparam logic [3:0] EXT64_START     = 4'd0;
   localparam logic [3:0] EXTLEN_END      = 4'd8;
   localparam logic [3:0] KEY_END         = 4'd4;

   typedef struct packed {
      logic        kind;
      logic [7:0]  data;
      logic        fin;
      logic [2:0]  rsv;
      logic [3:0]  opcode;
      logic        masked;
      logic [63:0] length;
      logic        last;
   } result_type;

   // key byte for a payload offset, first received key byte at offset 0
   function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] idx);
      logic [7:0] k;
      case (idx)
         2'd0: k = key[31:24];
         2'd1: k = key[23:16];
         2'd2: k = key[15:8];
         default: k = key[7:0];
      endcase
      return k;
   endfunction

endpackage

@@ design/wsfd_parser.sv @@
// frame header parser and payload unmasking for the websocket frame deframer
// depends on wsfd_pkg and websocket_frame_deframer_defines.svh
`include "websocket_frame_deframer_defines.svh"

module wsfd_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [7:0]           in_byte,
   output logic                 emit,
   output wsfd_pkg::result_type result
);

   wsfd_pkg::phase_type phase_ff, phase_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [8:0]  flags_ff, flags_in;
   logic [63:0] len_ff, len_in;
   logic [31:0] key_ff, key_in;
   logic [63:0] done_ff, done_in;

   logic [6:0]  len7;
   logic [3:0]  cnt_inc;
   logic [63:0] done_inc;
   logic        is_last;

   assign len7     = in_byte[6:0];
   assign cnt_inc  = cnt_ff + 4'd1;
   assign done_inc = done_ff + 64'd1;

   // next state
   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      flags_in = flags_ff;
      len_in   = len_ff;
      key_in   = key_ff;
      done_in  = done_ff;
      emit     = 1'b0;
      is_last  = 1'b0;
      case (phase_ff)
         wsfd_pkg::PH_BYTE1: begin
            flags_in = {in_byte[7], flags_ff[7:0]};
            key_in   = 32'd0;
            if (len7 <= wsfd_pkg::LEN7_MAX_DIRECT) begin
               len_in = {57'd0, len7};
               cnt_in = 4'd0;
               if (in_byte[7]) begin
                  phase_in = wsfd_pkg::PH_KEY;
               end else begin
                  done_in  = 64'd0;
                  emit     = 1'b1;
                  is_last  = (len7 == 7'd0);
                  phase_in = is_last ? wsfd_pkg::PH_BYTE0 : wsfd_pkg::PH_PAYLOAD;
               end
            end else begin
               len_in   = 64'd0;
               cnt_in   = (len7 == wsfd_pkg::LEN7_EXT16) ? wsfd_pkg::EXT16_START
                                                         : wsfd_pkg::EXT64_START;
               phase_in = wsfd_pkg::PH_EXTLEN;
            end
         end
         wsfd_pkg::PH_EXTLEN: begin
            len_in = {len_ff[55:0], in_byte};
            cnt_in = cnt_inc;
            if (cnt_inc >= wsfd_pkg::EXTLEN_END) begin
               cnt_in = 4'd0;
               if (flags_ff[8]) begin
                  phase_in = wsfd_pkg::PH_KEY;
               end else begin
                  done_in  = 64'd0;
                  emit     = 1'b1;
                  is_last  = (len_in == 64'd0);
                  phase_in = is_last ? wsfd_pkg::PH_BYTE0 : wsfd_pkg::PH_PAYLOAD;
               end
            end
         end
         wsfd_pkg::PH_KEY: begin
            key_in = {key_ff[23:0], in_byte};
            cnt_in = cnt_inc;
            if (cnt_inc >= wsfd_pkg::KEY_END) begin
               cnt_in   = 4'd0;
               done_in  = 64'd0;
               emit     = 1'b1;
               is_last  = (len_ff == 64'd0);
               phase_in = is_last ? wsfd_pkg::PH_BYTE0 : wsfd_pkg::PH_PAYLOAD;
            end
         end
         wsfd_pkg::PH_PAYLOAD: begin
            done_in = done_inc;
            emit    = 1'b1;
            is_last = (done_inc >= len_ff);
            if (is_last) begin
               phase_in = wsfd_pkg::PH_BYTE0;
            end
         end
         default: begin
            // first header byte, also taken for undefined phase codes
            flags_in = {1'b0, in_byte};
            cnt_in   = 4'd0;
            len_in   = 64'd0;
            key_in   = 32'd0;
            done_in  = 64'd0;
            phase_in = wsfd_pkg::PH_BYTE1;
         end
      endcase
   end

   // result fields, built from the updated header state
   always_comb begin
      result.kind   = (phase_ff == wsfd_pkg::PH_PAYLOAD) ? wsfd_pkg::KIND_PAYLOAD
                                                         : wsfd_pkg::KIND_HEADER;
      result.data   = (phase_ff == wsfd_pkg::PH_PAYLOAD)
                      ? (in_byte ^ wsfd_pkg::key_byte(key_ff, done_ff[1:0])) : 8'd0;
      result.fin    = flags_in[7];
      result.rsv    = flags_in[6:4];
      result.opcode = flags_in[3:0];
      result.masked = flags_in[8];
      result.length = len_in;
      result.last   = is_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= wsfd_pkg::PH_BYTE0;
         cnt_ff   <= 4'd0;
         flags_ff <= 9'd0;
         len_ff   <= 64'd0;
         key_ff   <= 32'd0;
         done_ff  <= 64'd0;
      end else if (in_valid) begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         flags_ff <= flags_in;
         len_ff   <= len_in;
         key_ff   <= key_in;
         done_ff  <= done_in;
      end
   end

   `WSFD_ASSERT_IMPLY(a_payload_below_length, phase_ff == wsfd_pkg::PH_PAYLOAD, done_ff < len_ff, "payload count reached length inside payload phase")
   `WSFD_ASSERT_IMPLY(a_key_count_range, phase_ff == wsfd_pkg::PH_KEY, cnt_ff < wsfd_pkg::KEY_END, "key byte count out of range")
   `WSFD_ASSERT_NEXT(a_last_returns_to_byte0, in_valid && emit && result.last, phase_ff == wsfd_pkg::PH_BYTE0, "frame end did not return to first header byte")
   `WSFD_ASSERT_IMPLY(a_payload_kind_phase, in_valid && emit && (result.kind == wsfd_pkg::KIND_PAYLOAD), phase_ff == wsfd_pkg::PH_PAYLOAD, "payload result outside payload phase")

endmodule

@@ design/websocket_frame_deframer.sv @@
// websocket frame deframer top level: input register, parser, result register
// depends on wsfd_pkg and wsfd_parser
//
// Takes a received websocket byte stream one request per cycle when not stalled
// and emits one header result when a frame header is complete (base length,
// optional 16- or 64-bit big-endian extension, optional 4-byte masking key), then
// one result per payload byte, unmasked with the key byte picked by the running
// payload offset. The last payload byte, or the header of a zero-length frame, is
// flagged last. Header bytes that complete nothing produce no result. Throughput
// is one request per clock unless the result register stalls; a request passes
// through the input register, then the result register. The clock rate is set by
// the 64-bit payload counter increment and its compare against the frame length.
// A request is processed only when the result register is empty or being drained,
// so req_ready follows rsp_ready through that single decision.
module websocket_frame_deframer (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_result_kind,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_fin_bit,
   output logic [2:0]  rsp_reserved_bits,
   output logic [3:0]  rsp_frame_opcode,
   output logic        rsp_masked_flag,
   output logic [63:0] rsp_payload_length,
   output logic        rsp_last_of_frame
);

   // input register
   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff, in_byte_in;

   // result register
   logic                 out_vld_ff, out_vld_in;
   wsfd_pkg::result_type out_res_ff, out_res_in;

   logic                 process;
   logic                 emit;
   wsfd_pkg::result_type result;

   // the held request moves on when the result slot is free or freeing up
   assign process   = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || process;

   wsfd_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .in_valid (process),
      .in_byte  (in_byte_ff),
      .emit     (emit),
      .result   (result)
   );

   always_comb begin
      in_vld_in  = in_vld_ff;
      in_byte_in = in_byte_ff;
      if (req_valid && req_ready) begin
         in_vld_in  = 1'b1;
         in_byte_in = req_in_byte;
      end else if (process) begin
         in_vld_in = 1'b0;
      end
   end

   always_comb begin
      out_vld_in = out_vld_ff;
      out_res_in = out_res_ff;
      if (process) begin
         // header bytes with nothing to report leave the slot empty
         out_vld_in = emit;
         out_res_in = result;
      end else if (rsp_ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_res_ff <= out_res_in;
   end

   assign rsp_valid          = out_vld_ff;
   assign rsp_result_kind    = out_res_ff.kind;
   assign rsp_data_byte      = out_res_ff.data;
   assign rsp_fin_bit        = out_res_ff.fin;
   assign rsp_reserved_bits  = out_res_ff.rsv;
   assign rsp_frame_opcode   = out_res_ff.opcode;
   assign rsp_masked_flag    = out_res_ff.masked;
   assign rsp_payload_length = out_res_ff.length;
   assign rsp_last_of_frame  = out_res_ff.last;

endmodule

@@ sim/wsfd_frame_checker.sv @@
// request/result monitor for the websocket frame deframer: tracks parser state,
// queues the deframed results it predicts and compares them field by field
// depends on wsfd_pkg
module wsfd_frame_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_result_kind,
   input  logic [7:0]  rsp_data_byte,
   input  logic        rsp_fin_bit,
   input  logic [2:0]  rsp_reserved_bits,
   input  logic [3:0]  rsp_frame_opcode,
   input  logic        rsp_masked_flag,
   input  logic [63:0] rsp_payload_length,
   input  logic        rsp_last_of_frame,
   output int          mismatch_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // parser state as seen from the byte stream
   wsfd_pkg::phase_type   rx_phase;
   logic [3:0]            hdr_cnt;
   logic [8:0]            hdr_flags;
   logic [63:0]           frame_len;
   logic [31:0]           mask_key;
   logic [63:0]           payload_seen;

   wsfd_pkg::result_type  deframed_queue[$];
   int                    mismatch_total = 0;

   assign mismatch_count = mismatch_total;

   task automatic flag_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      mismatch_total++;
      $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
   endtask

   task automatic push_result(input logic kind, input logic [7:0] data, input logic last);
      wsfd_pkg::result_type r;
      r.kind   = kind;
      r.data   = data;
      r.fin    = hdr_flags[7];
      r.rsv    = hdr_flags[6:4];
      r.opcode = hdr_flags[3:0];
      r.masked = hdr_flags[8];
      r.length = frame_len;
      r.last   = last;
      deframed_queue.push_back(r);
   endtask

   task automatic header_complete();
      payload_seen = '0;
      if (frame_len == '0) begin
         rx_phase = wsfd_pkg::PH_BYTE0;
         push_result(wsfd_pkg::KIND_HEADER, 8'h00, 1'b1);
      end else begin
         rx_phase = wsfd_pkg::PH_PAYLOAD;
         push_result(wsfd_pkg::KIND_HEADER, 8'h00, 1'b0);
      end
   endtask

   task automatic length_known();
      hdr_cnt = '0;
      if (hdr_flags[8])
         rx_phase = wsfd_pkg::PH_KEY;
      else
         header_complete();
   endtask

   task automatic deframe_byte(input logic [7:0] b);
      logic [7:0] k;
      case (rx_phase)
         wsfd_pkg::PH_BYTE1: begin
            hdr_flags[8] = b[7];
            mask_key     = '0;
            frame_len    = '0;
            if (b[6:0] <= wsfd_pkg::LEN7_MAX_DIRECT) begin
               frame_len = {57'd0, b[6:0]};
               length_known();
            end else begin
               hdr_cnt  = (b[6:0] == wsfd_pkg::LEN7_EXT16) ? wsfd_pkg::EXT16_START
                                                            : wsfd_pkg::EXT64_START;
               rx_phase = wsfd_pkg::PH_EXTLEN;
            end
         end
         wsfd_pkg::PH_EXTLEN: begin
            frame_len = {frame_len[55:0], b};
            hdr_cnt   = hdr_cnt + 4'd1;
            if (hdr_cnt >= wsfd_pkg::EXTLEN_END)
               length_known();
         end
         wsfd_pkg::PH_KEY: begin
            mask_key = {mask_key[23:0], b};
            hdr_cnt  = hdr_cnt + 4'd1;
            if (hdr_cnt >= wsfd_pkg::KEY_END) begin
               hdr_cnt = '0;
               header_complete();
            end
         end
         wsfd_pkg::PH_PAYLOAD: begin
            // key rotates with the running payload offset, first key byte on top
            k = 8'(mask_key >> (24 - 8 * int'(payload_seen[1:0])));
            payload_seen = payload_seen + 64'd1;
            if (payload_seen >= frame_len) begin
               push_result(wsfd_pkg::KIND_PAYLOAD, b ^ k, 1'b1);
               rx_phase = wsfd_pkg::PH_BYTE0;
            end else begin
               push_result(wsfd_pkg::KIND_PAYLOAD, b ^ k, 1'b0);
            end
         end
         default: begin
            hdr_flags    = {1'b0, b};
            hdr_cnt      = '0;
            frame_len    = '0;
            mask_key     = '0;
            payload_seen = '0;
            rx_phase     = wsfd_pkg::PH_BYTE1;
         end
      endcase
   endtask

   always @(posedge clock) begin
      wsfd_pkg::result_type want;
      if (reset) begin
         rx_phase     = wsfd_pkg::PH_BYTE0;
         hdr_cnt      = '0;
         hdr_flags    = '0;
         frame_len    = '0;
         mask_key     = '0;
         payload_seen = '0;
         deframed_queue.delete();
      end else begin
         // results first: a request taken at this edge cannot answer at it
         if (rsp_valid && rsp_ready) begin
            if (deframed_queue.size() == 0) begin
               flag_mismatch("result with nothing expected", 64'(rsp_result_kind), 64'd0);
            end else begin
               want = deframed_queue.pop_front();
               if (rsp_result_kind !== want.kind)
                  flag_mismatch("result_kind", 64'(rsp_result_kind), 64'(want.kind));
               if (rsp_data_byte !== want.data)
                  flag_mismatch("data_byte", 64'(rsp_data_byte), 64'(want.data));
               if (rsp_fin_bit !== want.fin)
                  flag_mismatch("fin_bit", 64'(rsp_fin_bit), 64'(want.fin));
               if (rsp_reserved_bits !== want.rsv)
                  flag_mismatch("reserved_bits", 64'(rsp_reserved_bits), 64'(want.rsv));
               if (rsp_frame_opcode !== want.opcode)
                  flag_mismatch("frame_opcode", 64'(rsp_frame_opcode), 64'(want.opcode));
               if (rsp_masked_flag !== want.masked)
                  flag_mismatch("masked_flag", 64'(rsp_masked_flag), 64'(want.masked));
               if (rsp_payload_length !== want.length)
                  flag_mismatch("payload_length", rsp_payload_length, want.length);
               if (rsp_last_of_frame !== want.last)
                  flag_mismatch("last_of_frame", 64'(rsp_last_of_frame), 64'(want.last));
            end
         end
         if (req_valid && req_ready)
            deframe_byte(req_in_byte);
      end
      pending_count <= deframed_queue.size();
   end

endmodule

@@ sim/websocket_frame_deframer_tb.sv @@
// top of the websocket frame deframer testbench: clock, reset, frame stimulus,
// random idling on both channels and the final verdict
// depends on wsfd_pkg, websocket_frame_deframer and wsfd_frame_checker
module websocket_frame_deframer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam time CLK_PERIOD   = 10ns;
   localparam int  RESET_CYCLES = 7;
   // about 1700 random request bytes after the directed frames
   localparam int  RANDOM_BYTES = 1700;
   // drain after the checker queue is empty, past the input and result registers
   localparam int  DRAIN_CYCLES = 12;
   // slowest run is a few thousand bytes with random idling; keep a wide margin
   localparam int  CYCLE_LIMIT  = 1_000_000;
   // 7-bit length code that announces a 64-bit extension
   localparam logic [6:0] LEN7_EXT64 = 7'd127;

   // how a frame carries its payload length
   typedef enum {ENC_DIRECT, ENC_EXT16, ENC_EXT64} len_enc_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_in_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_result_kind;
   logic [7:0]  rsp_data_byte;
   logic        rsp_fin_bit;
   logic [2:0]  rsp_reserved_bits;
   logic [3:0]  rsp_frame_opcode;
   logic        rsp_masked_flag;
   logic [63:0] rsp_payload_length;
   logic        rsp_last_of_frame;

   int fail_count;
   int expected_left;
   int cycle_count = 0;
   int bytes_sent = 0;
   // cycles left in a calm stretch where neither side starts a new idle
   int calm_left = 0;
   int stall_left = 0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   websocket_frame_deframer i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_in_byte        (req_in_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_fin_bit        (rsp_fin_bit),
      .rsp_reserved_bits  (rsp_reserved_bits),
      .rsp_frame_opcode   (rsp_frame_opcode),
      .rsp_masked_flag    (rsp_masked_flag),
      .rsp_payload_length (rsp_payload_length),
      .rsp_last_of_frame  (rsp_last_of_frame)
   );

   wsfd_frame_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_in_byte        (req_in_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_fin_bit        (rsp_fin_bit),
      .rsp_reserved_bits  (rsp_reserved_bits),
      .rsp_frame_opcode   (rsp_frame_opcode),
      .rsp_masked_flag    (rsp_masked_flag),
      .rsp_payload_length (rsp_payload_length),
      .rsp_last_of_frame  (rsp_last_of_frame),
      .mismatch_count     (fail_count),
      .pending_count      (expected_left)
   );

   // idle length: mostly from the short range, now and then a long pause
   function automatic int pick_idle();
      if ($urandom_range(0, 99) < 80)
         return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // result side back-pressure, with calm stretches shared by the sender
   always @(posedge clock) begin
      if (calm_left > 0)
         calm_left <= calm_left - 1;
      else if ($urandom_range(0, 199) == 0)
         calm_left <= $urandom_range(50, 300);

      if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (calm_left == 0 && $urandom_range(0, 99) < 25) begin
         rsp_ready  <= 1'b0;
         stall_left <= pick_idle() - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // one request byte: optional gap, then hold valid until the handshake
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = 0;
      if (calm_left == 0 && $urandom_range(0, 99) >= 55)
         gap = pick_idle();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   // whole frame: header, optional length extension, optional key, then n_bytes of payload
   // (n_bytes below the announced length leaves the frame open)
   task automatic send_frame(input logic [7:0] b0, input logic masked,
                             input len_enc_type enc, input logic [63:0] plen,
                             input longint unsigned n_bytes);
      logic [6:0] len7;
      int i;
      case (enc)
         ENC_DIRECT: len7 = plen[6:0];
         ENC_EXT16:  len7 = wsfd_pkg::LEN7_EXT16;
         default:    len7 = LEN7_EXT64;
      endcase
      send_byte(b0);
      send_byte({masked, len7});
      if (enc == ENC_EXT16) begin
         send_byte(plen[15:8]);
         send_byte(plen[7:0]);
      end else if (enc == ENC_EXT64) begin
         for (i = 7; i >= 0; i--)
            send_byte(plen[8*i +: 8]);
      end
      if (masked)
         repeat (4) send_byte(8'($urandom));
      for (longint unsigned n = 0; n < n_bytes; n++)
         send_byte(8'($urandom));
   endtask

   // random frame, mostly short payloads, some extended lengths kept small
   task automatic send_random_frame();
      int r;
      logic masked;
      len_enc_type enc;
      logic [63:0] plen;
      r = $urandom_range(0, 99);
      masked = ($urandom_range(0, 9) < 7);
      enc = ENC_DIRECT;
      if (r < 10) begin
         plen = 64'd0;
      end else if (r < 58) begin
         plen = 64'($urandom_range(1, 16));
      end else if (r < 67) begin
         plen = 64'($urandom_range(17, 124));
      end else if (r < 70) begin
         plen = 64'(wsfd_pkg::LEN7_MAX_DIRECT);
      end else if (r < 85) begin
         // non-minimal small values too
         enc = ENC_EXT16;
         plen = $urandom_range(0, 1) ? 64'($urandom_range(0, 125))
                                     : 64'($urandom_range(126, 400));
      end else begin
         enc = ENC_EXT64;
         plen = 64'($urandom_range(0, 40));
      end
      send_frame(8'($urandom), masked, enc, plen, plen);
   endtask

   initial begin
      int start_count;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // all header bits set, unmasked zero-length frame: header result is last
      send_frame(8'hFF, 1'b0, ENC_DIRECT, 64'd0, 64'd0);
      // all-zero byte 0, masked five-byte payload so the key wraps around
      send_frame(8'h00, 1'b1, ENC_DIRECT, 64'd5, 64'd5);
      // masked zero-length frame via a non-minimal 16-bit length of zero
      send_frame(8'h8A, 1'b1, ENC_EXT16, 64'd0, 64'd0);
      // unmasked one-byte frame via the 64-bit extension
      send_frame(8'h02, 1'b0, ENC_EXT64, 64'd1, 64'd1);

      start_count = bytes_sent;
      while (bytes_sent - start_count < RANDOM_BYTES)
         send_random_frame();

      // oversized 64-bit length with its top bit set: only its first bytes
      // can ever be sent, so this frame stays open to the end of the run
      send_frame(8'h81, 1'b1, ENC_EXT64, 64'hFFFF_FFFF_FFFF_FFFF, 64'd9);
      req_valid <= 1'b0;

      // let the checker count the last request before looking at its queue
      @(posedge clock);
      while (expected_left != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+design
design/wsfd_pkg.sv
design/wsfd_parser.sv
design/websocket_frame_deframer.sv
sim/wsfd_frame_checker.sv
sim/websocket_frame_deframer_tb.sv
